// ===== src/smws_pkg.sv =====
// ----------------------------------------------------------------------------
// smws_pkg: shared types and constants of the SPI master word shifter
// Command and result item layouts, register indexes, serial clock phase codes.
// ----------------------------------------------------------------------------
package smws_pkg;

   // Default and upper bound of the word length
   localparam int MAX_WORD_BITS_DEF = 32;
   localparam int LEN_W             = 7;   // holds any length up to 64
   localparam int BITS_W            = 6;   // width of the word_bits field
   localparam int DATA_W            = 32;  // width of write and read data
   localparam int CSR_IDX_W         = 2;

   // Opcode of an input item
   typedef enum logic {
      OP_WORD = 1'b0,
      OP_TICK = 1'b1
   } opcode_type;

   // Configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CLOCK_POLARITY     = 2'd0,
      CSR_CLOCK_PHASE        = 2'd1,
      CSR_LSB_FIRST          = 2'd2,
      CSR_SELECT_ACTIVE_HIGH = 2'd3
   } csr_index_type;

   // Half-bit phase of the serial clock
   typedef enum logic [1:0] {
      PH_LEAD  = 2'd0,   // next tick is a leading edge
      PH_TRAIL = 2'd1,   // next tick is a trailing edge
      PH_GAP_A = 2'd2,   // first lead-in or closing tick
      PH_GAP_B = 2'd3    // second lead-in or closing tick
   } phase_type;

   // Configuration as seen by the engine
   typedef struct packed {
      logic clock_polarity;
      logic clock_phase;
      logic lsb_first;
      logic select_active_high;
   } cfg_type;

   // Classified input item
   typedef struct packed {
      opcode_type          opcode;
      logic                is_read;
      logic [LEN_W-1:0]    length;      // already clamped to 1..max
      logic [DATA_W-1:0]   write_data;
      logic                end_of_frame;
      logic                miso_level;
   } cmd_type;

   // Result item
   typedef struct packed {
      logic                sclk_level;
      logic                mosi_level;
      logic                cs_level;
      logic                word_done;
      logic [DATA_W-1:0]   read_data;
      logic                busy_res;
   } rsp_type;

endpackage

// ===== src/smws_fifo2.sv =====
// ----------------------------------------------------------------------------
// smws_fifo2: two-entry queue
// Registered storage with push/full and pop/empty; a push and a pop may
// transfer in the same cycle.
// ----------------------------------------------------------------------------
module smws_fifo2 #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             empty
);

   logic [WIDTH-1:0] data_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff,  count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == 2'd2);
   assign empty   = (count_ff == 2'd0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = data_ff[rd_ptr_ff];

   // advance pointers and occupancy
   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop  ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // store the pushed entry
   always_ff @(posedge clock) begin
      if (do_push) begin
         data_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

// ===== src/smws_front.sv =====
// ----------------------------------------------------------------------------
// smws_front: input side of the word shifter
// Accepts items, clamps the word length, and queues them for the engine.
// ----------------------------------------------------------------------------
module smws_front #(
   parameter int MAX_WORD_BITS = smws_pkg::MAX_WORD_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              push,
   output logic                              full,
   input  logic                              opcode,
   input  logic                              is_read,
   input  logic [smws_pkg::BITS_W-1:0]       word_bits,
   input  logic [smws_pkg::DATA_W-1:0]       write_data,
   input  logic                              end_of_frame,
   input  logic                              miso_level,
   output logic                              cmd_valid,
   output smws_pkg::cmd_type                 cmd,
   input  logic                              cmd_take
);

   localparam logic [smws_pkg::LEN_W-1:0] MaxLen = smws_pkg::LEN_W'(MAX_WORD_BITS);

   smws_pkg::cmd_type                 item;
   logic [smws_pkg::LEN_W-1:0]        raw_len;
   logic [$bits(smws_pkg::cmd_type)-1:0] q_rdata;
   logic                              q_empty;

   // clamp length: zero means one bit, above the maximum saturates
   always_comb begin
      raw_len = smws_pkg::LEN_W'(word_bits);
      if (raw_len == '0) begin
         raw_len = smws_pkg::LEN_W'(1);
      end else if (raw_len > MaxLen) begin
         raw_len = MaxLen;
      end
   end

   // classify the item
   always_comb begin
      item.opcode       = smws_pkg::opcode_type'(opcode);
      item.is_read      = is_read;
      item.length       = raw_len;
      item.write_data   = write_data;
      item.end_of_frame = end_of_frame;
      item.miso_level   = miso_level;
   end

   smws_fifo2 #(
      .WIDTH ($bits(smws_pkg::cmd_type))
   ) u_cmd_q (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .wdata (item),
      .full  (full),
      .pop   (cmd_take),
      .rdata (q_rdata),
      .empty (q_empty)
   );

   assign cmd_valid = !q_empty;
   assign cmd       = smws_pkg::cmd_type'(q_rdata);

endmodule

// ===== src/smws_engine.sv =====
// ----------------------------------------------------------------------------
// smws_engine: serial engine of the word shifter
// Applies one queued item per cycle, if rsp_room, to the shift state; builds its result.
// ----------------------------------------------------------------------------
module smws_engine #(
   parameter int MAX_WORD_BITS = smws_pkg::MAX_WORD_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  smws_pkg::cfg_type cfg,
   input  logic              cmd_valid,
   input  smws_pkg::cmd_type cmd,
   output logic              cmd_take,
   input  logic              rsp_room,
   output logic              rsp_push,
   output smws_pkg::rsp_type rsp
);

   localparam int SW = MAX_WORD_BITS;
   localparam int LW = $clog2(MAX_WORD_BITS + 1);
   localparam int IW = $clog2(MAX_WORD_BITS);

   // shift state
   logic [SW-1:0]        shift_ff,  shift_in;
   logic [LW-1:0]        bit_idx_ff, bit_idx_in;
   logic [LW-1:0]        word_len_ff, word_len_in;
   smws_pkg::phase_type  phase_ff,  phase_in;
   logic                 reading_ff, reading_in;
   logic                 frame_ff,  frame_in;
   logic                 close_ff,  close_in;
   logic                 clk_pin_ff, clk_pin_in;
   logic                 mosi_ff,   mosi_in;

   logic                 fire, is_tick, busy_now, word_live;
   logic                 load, closing, sample_now, word_end, done;
   logic [LW-1:0]        new_len, bit_inc;
   logic [SW-1:0]        new_shift, shift_smp;
   logic [IW-1:0]        pos_cmd, pos_cur, pos_nxt;
   logic [smws_pkg::DATA_W-1:0] rdata;

   assign fire     = cmd_valid && rsp_room;
   assign cmd_take = fire;
   assign rsp_push = fire;

   // classify the step against the current state
   assign is_tick   = (cmd.opcode == smws_pkg::OP_TICK);
   assign word_live = (word_len_ff != '0);
   assign busy_now  = word_live || (frame_ff && close_ff);
   assign load      = !is_tick && !busy_now;
   assign closing   = is_tick && !word_live && frame_ff && close_ff;

   // bit positions: first bit of a new word, current bit, next bit
   assign new_len   = LW'(cmd.length);
   assign new_shift = cmd.is_read ? '0 : SW'(cmd.write_data);
   assign bit_inc   = bit_idx_ff + LW'(1);
   assign pos_cmd   = cfg.lsb_first ? '0 : IW'(new_len - LW'(1));
   assign pos_cur   = cfg.lsb_first ? IW'(bit_idx_ff)
                                    : IW'(word_len_ff - LW'(1) - bit_idx_ff);
   assign pos_nxt   = cfg.lsb_first ? IW'(bit_inc)
                                    : IW'(word_len_ff - LW'(1) - bit_inc);

   // sample MISO on the edge that the clock phase selects
   assign sample_now = is_tick && word_live && reading_ff && cmd.miso_level &&
                       (((phase_ff == smws_pkg::PH_LEAD)  && !cfg.clock_phase) ||
                        ((phase_ff == smws_pkg::PH_TRAIL) &&  cfg.clock_phase));
   assign shift_smp  = sample_now ? (shift_ff | (SW'(1) << pos_cur)) : shift_ff;

   assign word_end = is_tick && word_live && (phase_ff == smws_pkg::PH_TRAIL) &&
                     (bit_inc >= word_len_ff);

   // next half-bit phase
   always_comb begin
      phase_in = phase_ff;
      if (load) begin
         phase_in = frame_ff ? smws_pkg::PH_LEAD : smws_pkg::PH_GAP_A;
      end else if (is_tick && word_live) begin
         case (phase_ff)
            smws_pkg::PH_GAP_A: phase_in = smws_pkg::PH_GAP_B;
            smws_pkg::PH_GAP_B: phase_in = smws_pkg::PH_LEAD;
            smws_pkg::PH_LEAD:  phase_in = smws_pkg::PH_TRAIL;
            smws_pkg::PH_TRAIL: begin
               phase_in = (word_end && close_ff) ? smws_pkg::PH_GAP_A
                                                 : smws_pkg::PH_LEAD;
            end
            default: phase_in = smws_pkg::PH_LEAD;
         endcase
      end else if (closing) begin
         phase_in = (phase_ff == smws_pkg::PH_GAP_A) ? smws_pkg::PH_GAP_B
                                                      : smws_pkg::PH_LEAD;
      end
   end

   // next word, frame and pin state
   always_comb begin
      shift_in    = shift_smp;
      bit_idx_in  = bit_idx_ff;
      word_len_in = word_len_ff;
      reading_in  = reading_ff;
      frame_in    = frame_ff;
      close_in    = close_ff;
      clk_pin_in  = clk_pin_ff;
      mosi_in     = mosi_ff;
      done        = 1'b0;
      rdata       = '0;
      if (load) begin
         word_len_in = new_len;
         reading_in  = cmd.is_read;
         shift_in    = new_shift;
         bit_idx_in  = '0;
         close_in    = cmd.end_of_frame;
         frame_in    = 1'b1;
         if (!cfg.clock_phase && !cmd.is_read) begin
            mosi_in = new_shift[pos_cmd];
         end
      end else if (is_tick && word_live) begin
         case (phase_ff)
            smws_pkg::PH_LEAD: begin
               clk_pin_in = 1'b1;
               if (cfg.clock_phase && !reading_ff) begin
                  mosi_in = shift_ff[pos_cur];
               end
            end
            smws_pkg::PH_TRAIL: begin
               clk_pin_in = 1'b0;
               if (word_end) begin
                  done        = 1'b1;
                  rdata       = reading_ff ? smws_pkg::DATA_W'(shift_smp) : '0;
                  word_len_in = '0;
                  bit_idx_in  = '0;
               end else begin
                  bit_idx_in = bit_inc;
                  if (!cfg.clock_phase && !reading_ff) begin
                     mosi_in = shift_ff[pos_nxt];
                  end
               end
            end
            default: begin
               clk_pin_in = clk_pin_ff;
            end
         endcase
      end else if (closing && (phase_ff != smws_pkg::PH_GAP_A)) begin
         frame_in = 1'b0;
         close_in = 1'b0;
      end
   end

   // map pin state to pin levels
   always_comb begin
      rsp.sclk_level = clk_pin_in ^ cfg.clock_polarity;
      rsp.mosi_level = mosi_in;
      rsp.cs_level   = (frame_in == cfg.select_active_high);
      rsp.word_done  = done;
      rsp.read_data  = rdata;
      rsp.busy_res   = (word_len_in != '0) || (frame_in && close_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff    <= '0;
         bit_idx_ff  <= '0;
         word_len_ff <= '0;
         phase_ff    <= smws_pkg::PH_LEAD;
         reading_ff  <= 1'b0;
         frame_ff    <= 1'b0;
         close_ff    <= 1'b0;
         clk_pin_ff  <= 1'b0;
         mosi_ff     <= 1'b0;
      end else if (fire) begin
         shift_ff    <= shift_in;
         bit_idx_ff  <= bit_idx_in;
         word_len_ff <= word_len_in;
         phase_ff    <= phase_in;
         reading_ff  <= reading_in;
         frame_ff    <= frame_in;
         close_ff    <= close_in;
         clk_pin_ff  <= clk_pin_in;
         mosi_ff     <= mosi_in;
      end
   end

endmodule

// ===== src/spi_master_word_shifter.sv =====
// An item waits in the front queue, the engine turns it into a result, and the
// result waits in the result queue, whose head drives the rsp ports.
// Throughput: one item per cycle; the serial engine applies one queued item
// per cycle, and two-entry queues on each side absorb stalls.
// Reset (synchronous, active high) empties both queues, clears the registers
// to mode 0 with select active low, and leaves select inactive, clock idle.
// ----------------------------------------------------------------------------
// spi_master_word_shifter: SPI master that shifts words of 1 to 32 bits
// Front queue takes commands and half-bit ticks, the engine drives the pins,
// and a result queue holds pin levels and received words.
// ----------------------------------------------------------------------------
module spi_master_word_shifter #(
   parameter int MAX_WORD_BITS = smws_pkg::MAX_WORD_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   // configuration
   input  logic                               csr_we,
   input  logic [smws_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic                               csr_wdata,
   // input items
   input  logic                               req_push,
   output logic                               req_full,
   input  logic                               req_opcode,
   input  logic                               req_is_read,
   input  logic [smws_pkg::BITS_W-1:0]        req_word_bits,
   input  logic [smws_pkg::DATA_W-1:0]        req_write_data,
   input  logic                               req_end_of_frame,
   input  logic                               req_miso_level,
   // result items
   output logic                               rsp_empty,
   input  logic                               rsp_pop,
   output logic                               rsp_sclk_level,
   output logic                               rsp_mosi_level,
   output logic                               rsp_cs_level,
   output logic                               rsp_word_done,
   output logic [smws_pkg::DATA_W-1:0]        rsp_read_data,
   output logic                               rsp_busy_res
);

   smws_pkg::cfg_type cfg_ff, cfg_in;
   smws_pkg::cmd_type cmd;
   smws_pkg::rsp_type eng_rsp, out_rsp;
   logic              cmd_valid, cmd_take;
   logic              rsp_push, rsp_full;
   logic [$bits(smws_pkg::rsp_type)-1:0] q_rdata;

   // register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (smws_pkg::csr_index_type'(csr_index))
            smws_pkg::CSR_CLOCK_POLARITY:     cfg_in.clock_polarity     = csr_wdata;
            smws_pkg::CSR_CLOCK_PHASE:        cfg_in.clock_phase        = csr_wdata;
            smws_pkg::CSR_LSB_FIRST:          cfg_in.lsb_first          = csr_wdata;
            smws_pkg::CSR_SELECT_ACTIVE_HIGH: cfg_in.select_active_high = csr_wdata;
            default:                          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   smws_front #(
      .MAX_WORD_BITS (MAX_WORD_BITS)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .push         (req_push),
      .full         (req_full),
      .opcode       (req_opcode),
      .is_read      (req_is_read),
      .word_bits    (req_word_bits),
      .write_data   (req_write_data),
      .end_of_frame (req_end_of_frame),
      .miso_level   (req_miso_level),
      .cmd_valid    (cmd_valid),
      .cmd          (cmd),
      .cmd_take     (cmd_take)
   );

   smws_engine #(
      .MAX_WORD_BITS (MAX_WORD_BITS)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_take  (cmd_take),
      .rsp_room  (!rsp_full),
      .rsp_push  (rsp_push),
      .rsp       (eng_rsp)
   );

   smws_fifo2 #(
      .WIDTH ($bits(smws_pkg::rsp_type))
   ) u_rsp_q (
      .clock (clock),
      .reset (reset),
      .push  (rsp_push),
      .wdata (eng_rsp),
      .full  (rsp_full),
      .pop   (rsp_pop),
      .rdata (q_rdata),
      .empty (rsp_empty)
   );

   // drive result ports from the head of the result queue
   assign out_rsp        = smws_pkg::rsp_type'(q_rdata);
   assign rsp_sclk_level = out_rsp.sclk_level;
   assign rsp_mosi_level = out_rsp.mosi_level;
   assign rsp_cs_level   = out_rsp.cs_level;
   assign rsp_word_done  = out_rsp.word_done;
   assign rsp_read_data  = out_rsp.read_data;
   assign rsp_busy_res   = out_rsp.busy_res;

   // queues come out of reset empty
   a_reset_empty: assert property (@(posedge clock)
      reset |=> rsp_empty && !req_full)
      else $error("queues not empty after reset");

   // an item transfer is followed by a result in the result queue
   a_item_reaches_rsp: assert property (@(posedge clock) disable iff (reset)
      req_push && !req_full |-> ##2 !rsp_empty)
      else $error("accepted item did not reach the result queue");

   // received data only travels with a finished word
   a_rdata_with_done: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_word_done |-> rsp_read_data == '0)
      else $error("read data without word done");

endmodule

// ===== verif/tb_spi_master_word_shifter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_spi_master_word_shifter: self-checking bench for the SPI word shifter
// Drives word commands and half-bit ticks, mirrors the serial engine in a
// cycle-free model, and checks every pin-level result in order. Covers all
// clock modes, both bit orders, both select polarities and the ignored cases.
// ----------------------------------------------------------------------------
module tb_spi_master_word_shifter;

   localparam int WORD_MAX   = smws_pkg::MAX_WORD_BITS_DEF;
   localparam int IDLE_LIMIT = 1000;
   localparam int SETTLE     = 8;

   // One input item as the bench builds it
   typedef struct {
      smws_pkg::opcode_type op;
      logic              is_read;
      logic [5:0]        word_bits;
      logic [31:0]       write_data;
      logic              end_of_frame;
      logic              miso;
   } spi_item_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              csr_we = 1'b0;
   logic [1:0]        csr_index = '0;
   logic              csr_wdata = 1'b0;
   logic              req_push = 1'b0;
   logic              req_full;
   logic              req_opcode = 1'b0;
   logic              req_is_read = 1'b0;
   logic [5:0]        req_word_bits = '0;
   logic [31:0]       req_write_data = '0;
   logic              req_end_of_frame = 1'b0;
   logic              req_miso_level = 1'b0;
   logic              rsp_empty;
   logic              rsp_pop = 1'b0;
   logic              rsp_sclk_level;
   logic              rsp_mosi_level;
   logic              rsp_cs_level;
   logic              rsp_word_done;
   logic [31:0]       rsp_read_data;
   logic              rsp_busy_res;

   // Mirror of the serial engine and its registers
   smws_pkg::cfg_type   mode;
   logic [31:0]         m_shift;
   logic [5:0]          m_bit;
   smws_pkg::phase_type m_phase;
   logic [5:0]          m_len;
   logic                m_read;
   logic                m_frame;
   logic                m_close;
   logic                pin_clk;
   logic                pin_mosi;
   logic                pin_sel;

   smws_pkg::rsp_type pending_pins[$];
   smws_pkg::rsp_type want;
   int                mismatches = 0;
   int                shaped_items = 0;
   int                idle_cycles = 0;
   int                stall_left = 0;
   bit                gaps_on = 1'b1;

   spi_master_word_shifter uut (
      .clock(clock), .reset(reset),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .req_push(req_push), .req_full(req_full), .req_opcode(req_opcode),
      .req_is_read(req_is_read), .req_word_bits(req_word_bits),
      .req_write_data(req_write_data), .req_end_of_frame(req_end_of_frame),
      .req_miso_level(req_miso_level),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop),
      .rsp_sclk_level(rsp_sclk_level), .rsp_mosi_level(rsp_mosi_level),
      .rsp_cs_level(rsp_cs_level), .rsp_word_done(rsp_word_done),
      .rsp_read_data(rsp_read_data), .rsp_busy_res(rsp_busy_res)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // Engine mirror
   // ------------------------------------------------------------------------
   function automatic logic shifter_busy();
      return (m_len != 6'd0) || (m_frame && m_close);
   endfunction

   function automatic logic [4:0] bit_pos(input logic [5:0] i);
      logic [5:0] p;
      p = mode.lsb_first ? i : m_len - 6'd1 - i;
      return p[4:0];
   endfunction

   function automatic void reset_engine();
      mode     = '0;
      m_shift  = '0;
      m_bit    = '0;
      m_phase  = smws_pkg::PH_LEAD;
      m_len    = '0;
      m_read   = 1'b0;
      m_frame  = 1'b0;
      m_close  = 1'b0;
      pin_clk  = 1'b0;
      pin_mosi = 1'b0;
      pin_sel  = 1'b0;
   endfunction

   // Apply one item to the mirror and return the pin levels it leaves
   function automatic smws_pkg::rsp_type predict_pins(input spi_item_type it,
                                                      output logic ignored);
      smws_pkg::rsp_type r;
      int                len;
      r = '0;
      ignored = 1'b0;
      if (it.op == smws_pkg::OP_WORD) begin
         if (shifter_busy()) begin
            ignored = 1'b1;
         end else begin
            len = int'(it.word_bits);
            if (len == 0) len = 1;
            if (len > WORD_MAX) len = WORD_MAX;
            m_len   = len[5:0];
            m_read  = it.is_read;
            m_shift = it.is_read ? 32'd0 : it.write_data;
            m_bit   = '0;
            m_close = it.end_of_frame;
            if (!m_frame) begin
               m_frame = 1'b1;
               pin_sel = 1'b1;
               m_phase = smws_pkg::PH_GAP_A;
            end else begin
               m_phase = smws_pkg::PH_LEAD;
            end
            // mode 0 style: set up the first bit before the leading edge
            if (!mode.clock_phase && !m_read) pin_mosi = m_shift[bit_pos(m_bit)];
         end
      end else if (m_len != 6'd0) begin
         case (m_phase)
            smws_pkg::PH_GAP_A: m_phase = smws_pkg::PH_GAP_B;
            smws_pkg::PH_GAP_B: m_phase = smws_pkg::PH_LEAD;
            smws_pkg::PH_LEAD: begin
               pin_clk = 1'b1;
               if (!mode.clock_phase) begin
                  if (m_read && it.miso) m_shift[bit_pos(m_bit)] = 1'b1;
               end else if (!m_read) begin
                  pin_mosi = m_shift[bit_pos(m_bit)];
               end
               m_phase = smws_pkg::PH_TRAIL;
            end
            default: begin
               pin_clk = 1'b0;
               if (mode.clock_phase && m_read && it.miso) m_shift[bit_pos(m_bit)] = 1'b1;
               m_bit = m_bit + 6'd1;
               if (m_bit >= m_len) begin
                  r.word_done = 1'b1;
                  if (m_read) r.read_data = m_shift;
                  m_len   = '0;
                  m_bit   = '0;
                  m_phase = m_close ? smws_pkg::PH_GAP_A : smws_pkg::PH_LEAD;
               end else begin
                  if (!mode.clock_phase && !m_read) pin_mosi = m_shift[bit_pos(m_bit)];
                  m_phase = smws_pkg::PH_LEAD;
               end
            end
         endcase
      end else if (m_frame && m_close) begin
         // closing ticks, then release select
         if (m_phase == smws_pkg::PH_GAP_A) begin
            m_phase = smws_pkg::PH_GAP_B;
         end else begin
            m_phase = smws_pkg::PH_LEAD;
            m_frame = 1'b0;
            m_close = 1'b0;
            pin_sel = 1'b0;
         end
      end else begin
         ignored = 1'b1;
      end
      r.sclk_level = pin_clk ^ mode.clock_polarity;
      r.mosi_level = pin_mosi;
      r.cs_level   = (pin_sel == mode.select_active_high);
      r.busy_res   = shifter_busy();
      return r;
   endfunction

   // ------------------------------------------------------------------------
   // Result side: random pop stalls and in-order checking
   // ------------------------------------------------------------------------
   always @(negedge clock) begin
      if (gaps_on && stall_left == 0 && $urandom_range(0, 7) == 0)
         stall_left = $urandom_range(1, 10);
      if (stall_left != 0) begin
         rsp_pop <= 1'b0;
         stall_left = stall_left - 1;
      end else begin
         rsp_pop <= 1'b1;
      end
   end

   function automatic void check_field(input string name, input logic [31:0] exp_v,
                                       input logic [31:0] act_v);
      if (act_v !== exp_v) begin
         $error("%s: expected %h, got %h", name, exp_v, act_v);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_pop && !rsp_empty) begin
         if (pending_pins.size() == 0) begin
            $error("result transfer with no expectation waiting");
            mismatches++;
         end else begin
            want = pending_pins.pop_front();
            check_field("sclk_level", 32'(want.sclk_level), 32'(rsp_sclk_level));
            check_field("mosi_level", 32'(want.mosi_level), 32'(rsp_mosi_level));
            check_field("cs_level",   32'(want.cs_level),   32'(rsp_cs_level));
            check_field("word_done",  32'(want.word_done),  32'(rsp_word_done));
            check_field("read_data",  want.read_data,       rsp_read_data);
            check_field("busy_res",   32'(want.busy_res),   32'(rsp_busy_res));
         end
      end
   end

   // Stop the run when nothing transfers for too long
   initial begin
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_push && !req_full) || (rsp_pop && !rsp_empty)) idle_cycles = 0;
         else idle_cycles++;
      end
      $display("Verification failed");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------
   task automatic send_item(input spi_item_type it);
      int   n;
      logic ignored;
      // hold off the sender for a random burst
      if (gaps_on && $urandom_range(0, 7) == 0) begin
         n = $urandom_range(1, 10);
         repeat (n) begin
            @(negedge clock);
            req_push <= 1'b0;
         end
      end
      @(negedge clock);
      req_push         <= 1'b1;
      req_opcode       <= it.op;
      req_is_read      <= it.is_read;
      req_word_bits    <= it.word_bits;
      req_write_data   <= it.write_data;
      req_end_of_frame <= it.end_of_frame;
      req_miso_level   <= it.miso;
      @(posedge clock);
      while (req_full) @(posedge clock);
      pending_pins.push_back(predict_pins(it, ignored));
      if (!ignored) shaped_items++;
   endtask

   task automatic send_word(input logic rd, input logic [5:0] bits,
                            input logic [31:0] data, input logic eof);
      spi_item_type it;
      it.op           = smws_pkg::OP_WORD;
      it.is_read      = rd;
      it.word_bits    = bits;
      it.write_data   = data;
      it.end_of_frame = eof;
      it.miso         = 1'($urandom_range(0, 1));
      send_item(it);
   endtask

   // Command fields of a tick carry junk; the block must ignore them
   task automatic send_tick(input logic miso);
      spi_item_type it;
      it.op           = smws_pkg::OP_TICK;
      it.is_read      = 1'($urandom_range(0, 1));
      it.word_bits    = 6'($urandom_range(0, 63));
      it.write_data   = $urandom;
      it.end_of_frame = 1'($urandom_range(0, 1));
      it.miso         = miso;
      send_item(it);
   endtask

   task automatic tick_until_idle();
      while (shifter_busy()) send_tick(1'($urandom_range(0, 1)));
   endtask

   // Stop sending and wait for every expected result
   task automatic drain_results();
      @(negedge clock);
      req_push <= 1'b0;
      while (pending_pins.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic csr_write(input smws_pkg::csr_index_type idx, input logic val);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         smws_pkg::CSR_CLOCK_POLARITY: mode.clock_polarity     = val;
         smws_pkg::CSR_CLOCK_PHASE:    mode.clock_phase        = val;
         smws_pkg::CSR_LSB_FIRST:      mode.lsb_first          = val;
         default:                      mode.select_active_high = val;
      endcase
   endtask

   task automatic set_mode(input logic cpol, input logic cpha, input logic lsb,
                           input logic sah);
      drain_results();
      csr_write(smws_pkg::CSR_CLOCK_POLARITY, cpol);
      csr_write(smws_pkg::CSR_CLOCK_PHASE, cpha);
      csr_write(smws_pkg::CSR_LSB_FIRST, lsb);
      csr_write(smws_pkg::CSR_SELECT_ACTIVE_HIGH, sah);
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   function automatic int pick_bits();
      int r;
      r = $urandom_range(0, 15);
      if (r == 0) return $urandom_range(0, 63);
      if (r == 1) return WORD_MAX;
      return $urandom_range(1, 8);
   endfunction

   function automatic logic [31:0] pick_data();
      int r;
      r = $urandom_range(0, 7);
      if (r == 0) return 32'd0;
      if (r == 1) return '1;
      return $urandom;
   endfunction

   // One frame of 1 to 3 words, with stray commands and the odd cut-short word
   task automatic run_frame(input int forced_bits);
      int nwords;
      int w;
      int bits;
      int cut;
      nwords = $urandom_range(1, 3);
      for (w = 0; w < nwords; w++) begin
         bits = (w == 0 && forced_bits >= 0) ? forced_bits : pick_bits();
         send_word(1'($urandom_range(0, 1)), bits[5:0], pick_data(), w == nwords - 1);
         cut = ($urandom_range(0, 19) == 0) ? int'($urandom_range(1, 6)) : -1;
         while (shifter_busy() && cut != 0) begin
            if ($urandom_range(0, 15) == 0)
               send_word(1'($urandom_range(0, 1)), 6'($urandom_range(0, 63)), $urandom,
                         1'($urandom_range(0, 1)));
            else
               send_tick(1'($urandom_range(0, 1)));
            if (cut > 0) cut--;
         end
      end
   endtask

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------
   // Ticks with no frame change nothing
   task automatic test_idle_ticks();
      send_tick(1'b1);
      send_tick(1'b0);
   endtask

   // Zero length runs as one bit; commands in lead-in and closing are dropped
   task automatic test_short_frame_busy();
      send_word(1'b0, 6'd0, '1, 1'b1);
      send_tick(1'b0);
      send_word(1'b0, 6'd63, 32'd0, 1'b0);
      send_tick(1'b1);
      send_tick(1'b0);
      send_tick(1'b1);
      send_tick(1'b0);
      send_word(1'b1, 6'd4, 32'd0, 1'b1);
      tick_until_idle();
   endtask

   // Read keeps MOSI where the previous write left it
   task automatic test_read_word();
      send_word(1'b0, 6'd1, 32'h0000_0001, 1'b0);
      tick_until_idle();
      send_word(1'b1, 6'd2, 32'hffff_ffff, 1'b1);
      send_tick(1'b0);
      send_tick(1'b1);
      send_tick(1'b1);
      send_tick(1'b1);
      send_tick(1'b0);
      send_tick(1'b0);
      tick_until_idle();
   endtask

   // Change every register in the middle of a word
   task automatic test_midword_config();
      set_mode(1'b0, 1'b1, 1'b0, 1'b0);
      send_word(1'b0, 6'd2, 32'h0000_0002, 1'b1);
      repeat (4) send_tick(1'($urandom_range(0, 1)));
      set_mode(1'b1, 1'b0, 1'b1, 1'b1);
      tick_until_idle();
   endtask

   // Phases of random frames; the last one runs with no idling
   task automatic test_random_traffic();
      int ph;
      int target;
      for (ph = 0; ph < 6; ph++) begin
         case (ph)
            0: set_mode(1'b0, 1'b0, 1'b0, 1'b0);
            1: set_mode(1'b1, 1'b1, 1'b1, 1'b1);
            default: set_mode(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                              1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
         endcase
         gaps_on = (ph != 5);
         target  = shaped_items + 250;
         run_frame(ph == 0 ? 63 : (ph == 1 ? 0 : (ph == 2 ? WORD_MAX : -1)));
         while (shaped_items < target) begin
            if ($urandom_range(0, 9) == 0) send_tick(1'($urandom_range(0, 1)));
            run_frame(-1);
            if (gaps_on && $urandom_range(0, 11) == 0) drain_results();
         end
      end
   endtask

   initial begin
      reset_engine();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_idle_ticks();
      test_short_frame_busy();
      test_read_word();
      test_midword_config();
      test_random_traffic();
      drain_results();
      repeat (SETTLE) @(posedge clock);
      if (mismatches == 0 && pending_pins.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
